[src/ezr_pkg.sv]
// Shared constants, types and the arctangent table for the Euler-to-matrix block.
`timescale 1ns / 1ps

package ezr_pkg;

    localparam int FRAC_BITS_DEF  = 14;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int OUT_W          = 16;

    // CORDIC runs on a 32-bit phase (2^32 = full turn) with Q2.30 x and y
    localparam int CORDIC_STEPS = 24;
    localparam int PHASE_W      = 32;
    localparam int CW           = 33;

    localparam logic signed [CW-1:0]      CORDIC_GAIN  = 33'sd652032874;
    localparam logic signed [PHASE_W-1:0] QUARTER_POS  = 32'sh40000000;
    localparam logic signed [PHASE_W-1:0] QUARTER_NEG  = -32'sh40000000;

    typedef struct packed {
        logic signed [CW-1:0]      x;
        logic signed [CW-1:0]      y;
        logic signed [PHASE_W-1:0] z;
        logic                      flip;
    } lane_t;

    typedef struct packed {
        logic  valid;
        lane_t roll;
        lane_t pitch;
        lane_t yaw;
    } cstage_t;

    function automatic logic signed [PHASE_W-1:0] atan_step(input int step);
        logic signed [PHASE_W-1:0] a;
        case (step)
            0:       a = 32'sd536870912;
            1:       a = 32'sd316933406;
            2:       a = 32'sd167458907;
            3:       a = 32'sd85004756;
            4:       a = 32'sd42667331;
            5:       a = 32'sd21354465;
            6:       a = 32'sd10680350;
            7:       a = 32'sd5340245;
            8:       a = 32'sd2670163;
            9:       a = 32'sd1335087;
            10:      a = 32'sd667544;
            11:      a = 32'sd333772;
            12:      a = 32'sd166886;
            13:      a = 32'sd83443;
            14:      a = 32'sd41722;
            15:      a = 32'sd20861;
            16:      a = 32'sd10430;
            17:      a = 32'sd5215;
            18:      a = 32'sd2608;
            19:      a = 32'sd1304;
            20:      a = 32'sd652;
            21:      a = 32'sd326;
            22:      a = 32'sd163;
            23:      a = 32'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[src/ezr_in_if.sv]
// Input channel: one beat carries roll, pitch and yaw binary angles.
`timescale 1ns / 1ps

interface ezr_in_if #(
    parameter int ANGLE_BITS = ezr_pkg::ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] roll;
    logic signed [ANGLE_BITS-1:0] pitch;
    logic signed [ANGLE_BITS-1:0] yaw;

    modport source (output valid, output roll, output pitch, output yaw, input ready);
    modport sink   (input valid, input roll, input pitch, input yaw, output ready);
endinterface

[src/ezr_out_if.sv]
// Output channel: one beat carries the nine rotation matrix entries.
`timescale 1ns / 1ps

interface ezr_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ezr_pkg::OUT_W-1:0]  m00;
    logic signed [ezr_pkg::OUT_W-1:0]  m01;
    logic signed [ezr_pkg::OUT_W-1:0]  m02;
    logic signed [ezr_pkg::OUT_W-1:0]  m10;
    logic signed [ezr_pkg::OUT_W-1:0]  m11;
    logic signed [ezr_pkg::OUT_W-1:0]  m12;
    logic signed [ezr_pkg::OUT_W-1:0]  m20;
    logic signed [ezr_pkg::OUT_W-1:0]  m21;
    logic signed [ezr_pkg::OUT_W-1:0]  m22;

    modport source (output valid, output m00, output m01, output m02, output m10,
                    output m11, output m12, output m20, output m21, output m22,
                    input ready);
    modport sink   (input valid, input m00, input m01, input m02, input m10,
                    input m11, input m12, input m20, input m21, input m22,
                    output ready);
endinterface

[src/euler_zyx_to_rotation_matrix_top.sv]
// Top level: Euler ZYX angles to rotation matrix, fully pipelined.
`timescale 1ns / 1ps

// Converts a roll/pitch/yaw triple of binary angles (2^(ANGLE_BITS-1) = pi)
// into the nine entries of R = Rz(yaw)*Ry(pitch)*Rx(roll) in signed
// Q1.FRAC_BITS, each clamped to +-1.0 and carried in a 16-bit field. The block
// takes one triple per clock while the output is not stalled. Each matrix
// passes a fold stage that brings the phases into +-pi/2, a chain of 24 CORDIC
// cells (one rotation step each, all three angles side by side) that produces
// the sines and cosines, a rounding stage, and stages of multiply, round and
// add that build the entries, the last being the output register. The whole
// pipeline advances together; when a finished matrix is not taken it holds,
// and input ready drops until the output beat leaves. No state survives
// between beats, so any idle pattern on either side gives the same results.
module euler_zyx_to_rotation_matrix_top #(
    parameter int FRAC_BITS  = ezr_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ezr_pkg::ANGLE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ezr_in_if.sink    angles,
    ezr_out_if.source matrix
);

    localparam int SW = FRAC_BITS + 2;
    localparam int SH = 30 - FRAC_BITS;
    localparam int RW = ezr_pkg::CW + 2;
    localparam logic signed [RW-1:0] HALF_R = RW'(1) << SH;
    localparam logic signed [RW-1:0] ONE_R  = RW'(1) << FRAC_BITS;
    localparam logic signed [SW-1:0] ONE_S  = SW'(1) << FRAC_BITS;

    typedef logic signed [SW-1:0] unit_t;

    // Place the angle on the 32-bit phase circle and fold it into +-pi/2.
    // Moving by pi only toggles the phase sign bit.
    function automatic ezr_pkg::lane_t fold(input logic [ANGLE_BITS-1:0] raw);
        logic [ezr_pkg::PHASE_W-1:0]        ph;
        logic signed [ezr_pkg::PHASE_W-1:0] z;
        ezr_pkg::lane_t                     l;
        ph = ezr_pkg::PHASE_W'(raw) << (ezr_pkg::PHASE_W - ANGLE_BITS);
        z  = signed'(ph);
        l.x    = ezr_pkg::CORDIC_GAIN;
        l.y    = '0;
        l.flip = 1'b0;
        if (z > ezr_pkg::QUARTER_POS || z < ezr_pkg::QUARTER_NEG)
        begin
            z      = {~z[ezr_pkg::PHASE_W-1], z[ezr_pkg::PHASE_W-2:0]};
            l.flip = 1'b1;
        end
        l.z = z;
        return l;
    endfunction

    // Undo the fold, round Q2.30 to Q1.FRAC_BITS half up, clamp to +-1.0.
    // Pre-doubling lets the same form cover a zero-bit shift.
    function automatic unit_t to_unit(input logic signed [ezr_pkg::CW-1:0] v,
                                      input logic neg);
        logic signed [RW-1:0] w;
        logic signed [RW-1:0] r;
        w = RW'(v);
        if (neg)
            w = -w;
        r = ((w <<< 1) + HALF_R) >>> (SH + 1);
        if (r > ONE_R)
            r = ONE_R;
        else if (r < -ONE_R)
            r = -ONE_R;
        return SW'(r);
    endfunction

    // Global advance: move everything when the output slot is free or taken.
    logic en;
    logic mx_valid;

    assign en           = !mx_valid || matrix.ready;
    assign angles.ready = en;

    // Fold stage
    logic                  fold_valid_reg;
    ezr_pkg::lane_t        fold_roll_reg, fold_pitch_reg, fold_yaw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_valid_reg <= 1'b0;
        else if (en)
            fold_valid_reg <= angles.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_roll_reg  <= fold(angles.roll);
            fold_pitch_reg <= fold(angles.pitch);
            fold_yaw_reg   <= fold(angles.yaw);
        end
    end

    // CORDIC chain: each cell does one rotation step and hands on to the next
    ezr_pkg::cstage_t chain [0:ezr_pkg::CORDIC_STEPS];
    logic [ezr_pkg::CORDIC_STEPS:0] chain_valid;

    assign chain[0].valid = fold_valid_reg;
    assign chain[0].roll  = fold_roll_reg;
    assign chain[0].pitch = fold_pitch_reg;
    assign chain[0].yaw   = fold_yaw_reg;

    genvar gi;
    generate
        for (gi = 0; gi < ezr_pkg::CORDIC_STEPS; gi++)
        begin : g_cell
            ezr_cordic_cell #(
                .STEP (gi)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en),
                .prev  (chain[gi]),
                .cur   (chain[gi+1])
            );
        end
        for (gi = 0; gi <= ezr_pkg::CORDIC_STEPS; gi++)
        begin : g_vtap
            assign chain_valid[gi] = chain[gi].valid;
        end
    endgenerate

    // Sine/cosine rounding stage
    logic  sc_valid_reg;
    unit_t sr_reg, cr_reg, sp_reg, cp_reg, sy_reg, cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_valid_reg <= 1'b0;
        else if (en)
            sc_valid_reg <= chain[ezr_pkg::CORDIC_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg <= to_unit(chain[ezr_pkg::CORDIC_STEPS].roll.y,
                              chain[ezr_pkg::CORDIC_STEPS].roll.flip);
            cr_reg <= to_unit(chain[ezr_pkg::CORDIC_STEPS].roll.x,
                              chain[ezr_pkg::CORDIC_STEPS].roll.flip);
            sp_reg <= to_unit(chain[ezr_pkg::CORDIC_STEPS].pitch.y,
                              chain[ezr_pkg::CORDIC_STEPS].pitch.flip);
            cp_reg <= to_unit(chain[ezr_pkg::CORDIC_STEPS].pitch.x,
                              chain[ezr_pkg::CORDIC_STEPS].pitch.flip);
            sy_reg <= to_unit(chain[ezr_pkg::CORDIC_STEPS].yaw.y,
                              chain[ezr_pkg::CORDIC_STEPS].yaw.flip);
            cy_reg <= to_unit(chain[ezr_pkg::CORDIC_STEPS].yaw.x,
                              chain[ezr_pkg::CORDIC_STEPS].yaw.flip);
        end
    end

    // Matrix products; its last stage is the output register
    ezr_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sc_valid_reg),
        .sr        (sr_reg),
        .cr        (cr_reg),
        .sp        (sp_reg),
        .cp        (cp_reg),
        .sy        (sy_reg),
        .cy        (cy_reg),
        .out_valid (mx_valid),
        .m00       (matrix.m00),
        .m01       (matrix.m01),
        .m02       (matrix.m02),
        .m10       (matrix.m10),
        .m11       (matrix.m11),
        .m12       (matrix.m12),
        .m20       (matrix.m20),
        .m21       (matrix.m21),
        .m22       (matrix.m22)
    );

    assign matrix.valid = mx_valid;

    // An accepted beat enters the fold stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid && angles.ready |=> fold_valid_reg)
        else $error("accepted beat missing from fold stage");

    // A stall freezes the CORDIC chain occupancy
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(chain_valid))
        else $error("CORDIC chain moved during stall");

    // Rounded yaw sine and cosine stay within +-1.0
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        sc_valid_reg |-> (sy_reg <= ONE_S && sy_reg >= -ONE_S &&
                          cy_reg <= ONE_S && cy_reg >= -ONE_S))
        else $error("sine or cosine out of range");

endmodule

[src/ezr_cordic_cell.sv]
// One CORDIC rotation step applied to the roll, pitch and yaw lanes, registered.
`timescale 1ns / 1ps

module ezr_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  ezr_pkg::cstage_t prev,
    output ezr_pkg::cstage_t cur
);

    localparam logic signed [ezr_pkg::PHASE_W-1:0] ANGLE = ezr_pkg::atan_step(STEP);

    function automatic ezr_pkg::lane_t rotate(input ezr_pkg::lane_t l);
        ezr_pkg::lane_t             r;
        logic signed [ezr_pkg::CW-1:0] dx;
        logic signed [ezr_pkg::CW-1:0] dy;
        dx = l.y >>> STEP;
        dy = l.x >>> STEP;
        r  = l;
        if (l.z >= 0)
        begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - ANGLE;
        end
        else
        begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + ANGLE;
        end
        return r;
    endfunction

    logic           valid_reg;
    logic           valid_next;
    ezr_pkg::lane_t roll_reg, roll_next;
    ezr_pkg::lane_t pitch_reg, pitch_next;
    ezr_pkg::lane_t yaw_reg, yaw_next;

    always_comb
    begin
        valid_next = prev.valid;
        roll_next  = rotate(prev.roll);
        pitch_next = rotate(prev.pitch);
        yaw_next   = rotate(prev.yaw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign cur.valid = valid_reg;
    assign cur.roll  = roll_reg;
    assign cur.pitch = pitch_reg;
    assign cur.yaw   = yaw_reg;

endmodule

[src/ezr_matrix.sv]
// Product pipeline: forms the nine matrix entries from six rounded sines and cosines.
`timescale 1ns / 1ps

module ezr_matrix #(
    parameter int FRAC_BITS = ezr_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [FRAC_BITS+1:0]       sr,
    input  logic signed [FRAC_BITS+1:0]       cr,
    input  logic signed [FRAC_BITS+1:0]       sp,
    input  logic signed [FRAC_BITS+1:0]       cp,
    input  logic signed [FRAC_BITS+1:0]       sy,
    input  logic signed [FRAC_BITS+1:0]       cy,
    output logic                              out_valid,
    output logic [ezr_pkg::OUT_W-1:0]         m00,
    output logic [ezr_pkg::OUT_W-1:0]         m01,
    output logic [ezr_pkg::OUT_W-1:0]         m02,
    output logic [ezr_pkg::OUT_W-1:0]         m10,
    output logic [ezr_pkg::OUT_W-1:0]         m11,
    output logic [ezr_pkg::OUT_W-1:0]         m12,
    output logic [ezr_pkg::OUT_W-1:0]         m20,
    output logic [ezr_pkg::OUT_W-1:0]         m21,
    output logic [ezr_pkg::OUT_W-1:0]         m22
);

    localparam int SW = FRAC_BITS + 2;
    localparam int MW = 2 * SW;
    localparam int PW = MW + 1;
    localparam int EW = (SW > ezr_pkg::OUT_W) ? SW : ezr_pkg::OUT_W;
    localparam logic signed [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] ONE_P  = PW'(1) << FRAC_BITS;

    typedef logic signed [SW-1:0] unit_t;
    typedef logic signed [MW-1:0] prod_t;
    typedef logic signed [PW-1:0] psum_t;
    typedef logic [ezr_pkg::OUT_W-1:0] word_t;

    // round half up, then clamp to +-1.0
    function automatic unit_t rescale(input psum_t p);
        psum_t r;
        r = (p + HALF_P) >>> FRAC_BITS;
        if (r > ONE_P)
            r = ONE_P;
        else if (r < -ONE_P)
            r = -ONE_P;
        return SW'(r);
    endfunction

    function automatic word_t to_word(input unit_t v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        return e[ezr_pkg::OUT_W-1:0];
    endfunction

    function automatic prod_t mul(input unit_t a, input unit_t b);
        return MW'(a) * MW'(b);
    endfunction

    logic [4:0] valid_reg;

    // stage 1: first products
    prod_t p_t1_reg, p_t2_reg, p00_reg, p10_reg, p21_reg, p22_reg;
    prod_t q_sycr_reg, q_sysr_reg, q_cycr_reg, q_cysr_reg;
    unit_t sp1_reg, cy1_reg, sy1_reg;

    // stage 2: rounded inner terms and finished single products
    unit_t t1_reg, t2_reg, cy2_reg, sy2_reg;
    prod_t q_sycr2_reg, q_sysr2_reg, q_cycr2_reg, q_cysr2_reg;
    word_t w00_2_reg, w10_2_reg, w20_2_reg, w21_2_reg, w22_2_reg;

    // stage 3: outer products
    prod_t a01_reg, a02_reg, a11_reg, a12_reg;
    prod_t q_sycr3_reg, q_sysr3_reg, q_cycr3_reg, q_cysr3_reg;
    word_t w00_3_reg, w10_3_reg, w20_3_reg, w21_3_reg, w22_3_reg;

    // stage 4: exact two-term sums
    psum_t s01_reg, s02_reg, s11_reg, s12_reg;
    word_t w00_4_reg, w10_4_reg, w20_4_reg, w21_4_reg, w22_4_reg;

    // stage 5: output register
    word_t m00_reg, m01_reg, m02_reg, m10_reg, m11_reg, m12_reg, m20_reg, m21_reg, m22_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_t1_reg   <= mul(sp, sr);
            p_t2_reg   <= mul(sp, cr);
            p00_reg    <= mul(cy, cp);
            p10_reg    <= mul(sy, cp);
            p21_reg    <= mul(cp, sr);
            p22_reg    <= mul(cp, cr);
            q_sycr_reg <= mul(sy, cr);
            q_sysr_reg <= mul(sy, sr);
            q_cycr_reg <= mul(cy, cr);
            q_cysr_reg <= mul(cy, sr);
            sp1_reg    <= sp;
            cy1_reg    <= cy;
            sy1_reg    <= sy;

            t1_reg      <= rescale(PW'(p_t1_reg));
            t2_reg      <= rescale(PW'(p_t2_reg));
            cy2_reg     <= cy1_reg;
            sy2_reg     <= sy1_reg;
            q_sycr2_reg <= q_sycr_reg;
            q_sysr2_reg <= q_sysr_reg;
            q_cycr2_reg <= q_cycr_reg;
            q_cysr2_reg <= q_cysr_reg;
            w00_2_reg   <= to_word(rescale(PW'(p00_reg)));
            w10_2_reg   <= to_word(rescale(PW'(p10_reg)));
            w20_2_reg   <= to_word(-sp1_reg);
            w21_2_reg   <= to_word(rescale(PW'(p21_reg)));
            w22_2_reg   <= to_word(rescale(PW'(p22_reg)));

            a01_reg     <= mul(cy2_reg, t1_reg);
            a02_reg     <= mul(cy2_reg, t2_reg);
            a11_reg     <= mul(sy2_reg, t1_reg);
            a12_reg     <= mul(sy2_reg, t2_reg);
            q_sycr3_reg <= q_sycr2_reg;
            q_sysr3_reg <= q_sysr2_reg;
            q_cycr3_reg <= q_cycr2_reg;
            q_cysr3_reg <= q_cysr2_reg;
            w00_3_reg   <= w00_2_reg;
            w10_3_reg   <= w10_2_reg;
            w20_3_reg   <= w20_2_reg;
            w21_3_reg   <= w21_2_reg;
            w22_3_reg   <= w22_2_reg;

            s01_reg   <= PW'(a01_reg) - PW'(q_sycr3_reg);
            s02_reg   <= PW'(a02_reg) + PW'(q_sysr3_reg);
            s11_reg   <= PW'(a11_reg) + PW'(q_cycr3_reg);
            s12_reg   <= PW'(a12_reg) - PW'(q_cysr3_reg);
            w00_4_reg <= w00_3_reg;
            w10_4_reg <= w10_3_reg;
            w20_4_reg <= w20_3_reg;
            w21_4_reg <= w21_3_reg;
            w22_4_reg <= w22_3_reg;

            m00_reg <= w00_4_reg;
            m01_reg <= to_word(rescale(s01_reg));
            m02_reg <= to_word(rescale(s02_reg));
            m10_reg <= w10_4_reg;
            m11_reg <= to_word(rescale(s11_reg));
            m12_reg <= to_word(rescale(s12_reg));
            m20_reg <= w20_4_reg;
            m21_reg <= w21_4_reg;
            m22_reg <= w22_4_reg;
        end
    end

    assign out_valid = valid_reg[4];
    assign m00 = m00_reg;
    assign m01 = m01_reg;
    assign m02 = m02_reg;
    assign m10 = m10_reg;
    assign m11 = m11_reg;
    assign m12 = m12_reg;
    assign m20 = m20_reg;
    assign m21 = m21_reg;
    assign m22 = m22_reg;

endmodule
